FILE: rtl/prps_pkg.sv
// shared types and constants for the port range splitter
package prps_pkg;

    localparam int unsigned FIELD_W       = 16;
    localparam int unsigned LG_W          = 5;
    localparam int unsigned ADDR_BITS_DEF = 16;

    localparam logic [FIELD_W-1:0] MAX_PORT_RESET = 16'hFFFF;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] range_start;
        logic [FIELD_W-1:0] range_length;
    } prps_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] chunk_base;
        logic [LG_W-1:0]    chunk_log2_size;
        logic               status;
        logic               last_chunk;
    } prps_out_t;

    typedef struct packed {
        logic load;
        logic step;
    } prps_cmd_t;

    typedef struct packed {
        logic last;
    } prps_sts_t;

endpackage

FILE: rtl/prps_datapath.sv
// range check, chunk generator registers and output register
module prps_datapath import prps_pkg::*; #(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  prps_in_t           s_data,
    input  prps_cmd_t          cmd,
    output prps_sts_t          sts,
    output prps_out_t          m_data
);

    localparam int unsigned CALC_W = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 1;
    localparam logic [CALC_W-1:0] SPACE = {{(CALC_W-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

    logic [FIELD_W-1:0] max_port_reg;
    logic [CALC_W-1:0]  cur_reg, cur_next;
    logic [FIELD_W-1:0] rem_reg, rem_next;
    logic               err_reg, err_next;
    prps_out_t          out_reg, out_next;

    logic [CALC_W-1:0]  limit;
    logic [CALC_W-1:0]  range_end;
    logic               range_bad;
    logic [CALC_W-1:0]  low_bit;
    logic [FIELD_W-1:0] high_bit;
    logic               use_low;
    logic [FIELD_W-1:0] size;
    logic [LG_W-1:0]    size_lg;
    logic               is_last;

    always_comb begin
        limit     = (CALC_W'(max_port_reg) < SPACE) ? CALC_W'(max_port_reg) : SPACE;
        range_end = CALC_W'(s_data.range_start) + CALC_W'(s_data.range_length)
                    - CALC_W'(1);
        range_bad = (s_data.range_length == '0) || (range_end > limit);
    end

    // chunk size is the smaller of the alignment of cur and the top bit of what remains
    always_comb begin
        low_bit  = cur_reg & (~cur_reg + CALC_W'(1));
        high_bit = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (rem_reg[i]) begin
                high_bit = FIELD_W'(1) << i;
            end
        end
        use_low = (low_bit != '0) && (low_bit <= CALC_W'(rem_reg));
        size    = use_low ? low_bit[FIELD_W-1:0] : high_bit;
        size_lg = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (size[i]) begin
                size_lg = size_lg | LG_W'(i);
            end
        end
        is_last = err_reg || (rem_reg == size);
    end

    assign sts.last = is_last;

    always_comb begin
        cur_next = cur_reg;
        rem_next = rem_reg;
        err_next = err_reg;
        out_next = out_reg;
        if (cmd.load) begin
            cur_next = CALC_W'(s_data.range_start);
            rem_next = s_data.range_length;
            err_next = range_bad;
        end else if (cmd.step) begin
            cur_next = cur_reg + CALC_W'(size);
            rem_next = rem_reg - size;
            if (err_reg) begin
                out_next.chunk_base      = '0;
                out_next.chunk_log2_size = '0;
                out_next.status          = STATUS_ERROR;
            end else begin
                out_next.chunk_base      = cur_reg[FIELD_W-1:0];
                out_next.chunk_log2_size = size_lg;
                out_next.status          = STATUS_OK;
            end
            out_next.last_chunk = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_port_reg <= MAX_PORT_RESET;
        end else if (cfg_wr_en) begin
            max_port_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        err_reg <= err_next;
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

FILE: rtl/prps_ctrl.sv
// controller: accepts a range, then steps the datapath once per emitted chunk
module prps_ctrl import prps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output prps_cmd_t cmd,
    input  prps_sts_t sts
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = s_valid && (state_reg == ST_IDLE);
    // output register takes a chunk when empty or being drained
    assign cmd.step = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cmd.step && sts.last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cmd.step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/port_range_power_of_two_splitter.sv
// top level: splits a port range into aligned power-of-two chunks
// a range is accepted, then split into 1 to 30 chunks, stepped while the output is free
// a range holds the block until its last chunk steps; there is a single chunk step unit
// first chunk is loaded into the chunk registers, then stepped into the output register
// the next range is accepted while the last chunk still waits in the output register
// synchronous active-low reset empties the output and sets max_port to 65535
module port_range_power_of_two_splitter import prps_pkg::*; #(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  prps_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output prps_out_t          m_data
);

    prps_cmd_t cmd;
    prps_sts_t sts;

    prps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    prps_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_data      (m_data)
    );

endmodule

FILE: rtl/prps_checker.sv
// port-level checks for the port range splitter, bound to the top level
module prps_checker import prps_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input prps_out_t          m_data
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // after a range is accepted, the block is not ready in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("range accepted on consecutive cycles");

    // an error result is a lone, zeroed result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_ERROR) |->
        m_data.last_chunk && (m_data.chunk_base == '0) && (m_data.chunk_log2_size == '0))
        else $error("malformed error result");

    // every valid chunk is aligned to its size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_OK) |->
        ((32'(m_data.chunk_base) & ((32'd1 << m_data.chunk_log2_size) - 32'd1)) == 32'd0))
        else $error("chunk base not aligned");

endmodule

bind port_range_power_of_two_splitter prps_checker u_checker (.*);
